// ===== src/sap_pkg.sv =====
// Shared types, constants and the sine point function for the stereo allpass phaser.
`default_nettype none
package sap_pkg;

   // configuration register indexes
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENABLE        = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_STEP    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEPTH_GAIN    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FEEDBACK_GAIN = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DRY_GAIN      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_WET_GAIN      = 3'd5;

   localparam int PHASE_W = 32;
   localparam int STEP_W  = 24;
   localparam int GAIN_W  = 15;
   localparam int FBG_W   = 16;
   localparam int COEF_W  = 16;
   localparam int OPB_W   = 17;
   localparam int FRAC_SHIFT = 15;

   localparam logic [STEP_W-1:0] PHASE_STEP_RST    = 24'd89478;
   localparam logic [GAIN_W-1:0] DEPTH_GAIN_RST    = 15'd26214;
   localparam logic [FBG_W-1:0]  FEEDBACK_GAIN_RST = 16'd16384;
   localparam logic [GAIN_W-1:0] DRY_GAIN_RST      = 15'd23170;
   localparam logic [GAIN_W-1:0] WET_GAIN_RST      = 15'd23170;

   // 0.8 in Q1.15
   localparam logic signed [OPB_W-1:0] DEPTH_SCALE = 17'sd26214;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef logic signed [COEF_W-1:0] coef_type;

   // Sine point k of a table of 2^lg entries, Q1.15, Q30 Taylor series with quadrant symmetry
   function automatic coef_type sine_point(input int unsigned k, input int unsigned lg);
      longint unsigned t;
      longint unsigned u;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          r;
      longint unsigned quad;
      t = longint'(k) << (32 - lg);
      quad = (t >> 30) & 64'd3;
      u = t & 64'h3FFF_FFFF;
      if (quad[0]) begin
         u = 64'h4000_0000 - u;
      end
      x = (u * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 5; n++) begin
         term = (term * x2) >> 30;
         unique case (n)
            1: term = term / 6;
            2: term = term / 20;
            3: term = term / 42;
            4: term = term / 72;
            default: term = term / 110;
         endcase
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 16384) >>> 15;
      if (r > 32767) begin
         r = 32767;
      end
      if (quad[1]) begin
         r = -r;
      end
      return coef_type'(r);
   endfunction

endpackage
`default_nettype wire

// ===== src/sap_mul.sv =====
// Shared signed multiplier with registered product.
`default_nettype none
module sap_mul #(
   parameter int AW = 28,
   parameter int BW = 17
) (
   input  wire logic                    clock,
   input  wire logic signed [AW-1:0]    op_a,
   input  wire logic signed [BW-1:0]    op_b,
   output logic signed [AW+BW-1:0]      prod_ff
);
   logic signed [AW+BW-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

// ===== src/sap_clip.sv =====
// Soft clip y/(1+|y|) by a one-bit-per-cycle reciprocal divider.
`default_nettype none
module sap_clip #(
   parameter int SB = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [SB+3:0] y,
   output logic                      busy,
   output logic                      done,
   output logic signed [SB-1:0]      clip
);
   localparam int F  = SB - 1;
   localparam int IW = SB + 4;
   localparam int RW = SB + 5;
   localparam int CW = $clog2(F + 1);
   localparam logic [RW-1:0] ONE_R = RW'(1) << F;
   localparam logic [F:0]    ONE_Q = (F+1)'(1) << F;
   localparam logic [CW-1:0] LAST  = CW'(F);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] d_ff, d_in;
   logic [RW-1:0] r_ff, r_in;
   logic [F:0]    q_ff, q_in;
   logic          neg_ff, neg_in;
   logic [IW-1:0] mag;
   logic          ge;
   logic [RW-1:0] r_sub;
   logic [F:0]    q_ceil;
   logic [F:0]    m;

   assign mag = y[IW-1] ? IW'(-y) : IW'(y);
   assign ge = r_ff >= d_ff;
   assign r_sub = ge ? r_ff - d_ff : r_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         d_in    = ONE_R + RW'(mag);
         r_in    = ONE_R;
         q_in    = '0;
         neg_in  = y[IW-1];
      end else if (busy_ff) begin
         // one quotient bit, then shift the partial remainder
         q_in   = {q_ff[F-1:0], ge};
         r_in   = {r_sub[RW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   // round the quotient up, then 1 - q
   assign q_ceil = q_ff + (F+1)'(r_ff != '0);
   assign m      = ONE_Q - q_ceil;
   assign clip   = neg_ff ? -SB'(m) : SB'(m);
   assign busy   = busy_ff;
   assign done   = done_ff;

   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("clip divider restarted while busy");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("clip divider done while still busy");
   assert property (@(posedge clock) disable iff (reset) (busy_ff && !start) |=> q_ff != '0 || !$past(ge) || busy_ff || done_ff)
      else $error("clip divider lost its quotient");
endmodule
`default_nettype wire

// ===== src/stereo_allpass_phaser.sv =====
// Stereo allpass phaser: sequencer, state and configuration around one shared multiplier.
// With the effect enabled, one stereo pair passes the coefficient products, then for each
// channel the feedback, stage, dry and wet products and the soft clip. With the effect
// disabled it goes straight to output. A finished result waits until rsp_tready takes the last.
// One transaction is in work at a time. The pace comes from two things. The first is the
// single multiplier, which forms every product, eleven per channel at the default stage count
// plus two for the coefficient, with rounding and saturation of the results. The second is the
// soft-clip reciprocal, which gives one quotient bit per cycle. The LFO sine comes from a
// constant table built at elaboration. Configuration writes take effect at once and belong in
// idle periods. The block-end marker rides along unchanged on rsp_tlast.
`default_nettype none
module stereo_allpass_phaser #(
   parameter int STAGE_COUNT      = 4,
   parameter int SAMPLE_BITS      = 24,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // left_in, right_in
   input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   input  wire logic                                   req_tlast,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // left_out, right_out
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]          rsp_tdata,
   output logic                                        rsp_tlast,
   input  wire logic                                   csr_we,
   input  wire logic [sap_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  wire logic [sap_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   localparam int SB    = SAMPLE_BITS;
   localparam int IW    = SAMPLE_BITS + 4;
   localparam int BW    = sap_pkg::OPB_W;
   localparam int PW    = IW + BW;
   localparam int W     = PW + 2;
   localparam int TD_W  = ((2*SAMPLE_BITS+7)/8)*8;
   localparam int LG    = $clog2(SINE_TABLE_DEPTH);
   localparam int STG_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
   localparam logic [STG_W-1:0] STG_LAST = STG_W'(STAGE_COUNT - 1);
   localparam logic signed [W-1:0] HALF  = W'(1) <<< (sap_pkg::FRAC_SHIFT - 1);
   localparam logic signed [W-1:0] I_MAX = (W'(1) <<< (IW - 1)) - W'(1);
   localparam logic signed [W-1:0] I_MIN = -I_MAX - W'(1);
   localparam logic signed [W-1:0] S_MAX = (W'(1) <<< (SB - 1)) - W'(1);
   localparam logic signed [W-1:0] S_MIN = -S_MAX - W'(1);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_C1   = 5'd1;
   localparam logic [4:0] S_C1W  = 5'd2;
   localparam logic [4:0] S_C2   = 5'd3;
   localparam logic [4:0] S_C2W  = 5'd4;
   localparam logic [4:0] S_FB   = 5'd5;
   localparam logic [4:0] S_FBW  = 5'd6;
   localparam logic [4:0] S_AY   = 5'd7;
   localparam logic [4:0] S_AYW  = 5'd8;
   localparam logic [4:0] S_AM   = 5'd9;
   localparam logic [4:0] S_AMW  = 5'd10;
   localparam logic [4:0] S_DRY  = 5'd11;
   localparam logic [4:0] S_DRYW = 5'd12;
   localparam logic [4:0] S_WET  = 5'd13;
   localparam logic [4:0] S_WETW = 5'd14;
   localparam logic [4:0] S_DS   = 5'd15;
   localparam logic [4:0] S_DW   = 5'd16;
   localparam logic [4:0] S_DONE = 5'd17;

   // configuration
   logic                              enable_ff;
   logic [sap_pkg::STEP_W-1:0]        phase_step_ff;
   logic [sap_pkg::GAIN_W-1:0]        depth_gain_ff;
   logic [sap_pkg::FBG_W-1:0]         feedback_gain_ff;
   logic [sap_pkg::GAIN_W-1:0]        dry_gain_ff;
   logic [sap_pkg::GAIN_W-1:0]        wet_gain_ff;

   // block state
   logic [4:0]                        state_ff, state_in;
   logic [sap_pkg::PHASE_W-1:0]       phase_ff;
   logic signed [SB-1:0]              fb_ff  [2];
   logic signed [IW-1:0]              mem_ff [2][STAGE_COUNT];

   // working registers
   logic signed [SB-1:0]              smp_ff [2];
   logic signed [SB-1:0]              out_ff [2];
   logic                              last_ff;
   sap_pkg::coef_type                 c_ff;
   logic signed [IW-1:0]              x_ff;
   logic signed [IW-1:0]              xs_ff;
   logic signed [W-1:0]               acc_ff;
   logic                              ch_ff;
   logic [STG_W-1:0]                  stg_ff;
   logic                              rsp_valid_ff;
   logic [TD_W-1:0]                   rsp_data_ff;
   logic                              rsp_last_ff;

   sap_pkg::coef_type                 sine_rom [SINE_TABLE_DEPTH];
   sap_pkg::coef_type                 sine;
   logic signed [IW-1:0]              op_a;
   logic signed [BW-1:0]              op_b;
   logic signed [PW-1:0]              prod;
   logic signed [W-1:0]               pw;
   logic signed [W-1:0]               p_rnd;
   logic signed [W-1:0]               smp_w;
   logic signed [W-1:0]               mem_w;
   logic signed [IW-1:0]              fb_sum;
   logic signed [IW-1:0]              y_val;
   logic signed [IW-1:0]              m_val;
   logic signed [SB-1:0]              mix;
   logic                              accept;
   logic                              div_start;
   logic                              div_busy;
   logic                              div_done;
   logic signed [SB-1:0]              div_clip;

   function automatic logic signed [IW-1:0] sat_i(input logic signed [W-1:0] v);
      if (v > I_MAX) begin
         return IW'(I_MAX);
      end else if (v < I_MIN) begin
         return IW'(I_MIN);
      end
      return IW'(v);
   endfunction

   function automatic logic signed [SB-1:0] sat_s(input logic signed [W-1:0] v);
      if (v > S_MAX) begin
         return SB'(S_MAX);
      end else if (v < S_MIN) begin
         return SB'(S_MIN);
      end
      return SB'(v);
   endfunction

   function automatic logic signed [W-1:0] rnd15(input logic signed [W-1:0] v);
      return (v + HALF) >>> sap_pkg::FRAC_SHIFT;
   endfunction

   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
      assign sine_rom[g] = sap_pkg::sine_point(g, LG);
   end

   assign sine = sine_rom[phase_ff[sap_pkg::PHASE_W-1 -: LG]];

   // operand selection for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         S_C1: begin
            op_a = IW'(sine);
            op_b = BW'(signed'({1'b0, depth_gain_ff}));
         end
         S_C2: begin
            op_a = IW'(c_ff);
            op_b = sap_pkg::DEPTH_SCALE;
         end
         S_FB: begin
            op_a = IW'(fb_ff[ch_ff]);
            op_b = BW'(signed'(feedback_gain_ff));
         end
         S_AY, S_AM, S_WET: begin
            op_a = x_ff;
            op_b = (state_ff == S_WET) ? BW'(signed'({1'b0, wet_gain_ff})) : BW'(c_ff);
         end
         S_DRY: begin
            op_a = IW'(smp_ff[ch_ff]);
            op_b = BW'(signed'({1'b0, dry_gain_ff}));
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   sap_mul #(.AW(IW), .BW(BW)) u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   assign pw     = W'(prod);
   assign p_rnd  = rnd15(pw);
   assign smp_w  = W'(smp_ff[ch_ff]);
   assign mem_w  = W'(mem_ff[ch_ff][stg_ff]);
   assign fb_sum = sat_i(smp_w + p_rnd);
   assign y_val  = sat_i(mem_w - p_rnd);
   assign m_val  = sat_i(W'(xs_ff) + p_rnd);
   assign mix    = sat_s(rnd15(acc_ff + pw));

   assign div_start = state_ff == S_DS;

   sap_clip #(.SB(SB)) u_clip (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .y     (x_ff),
      .busy  (div_busy),
      .done  (div_done),
      .clip  (div_clip)
   );

   assign req_tready = state_ff == S_IDLE;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            state_in = enable_ff ? S_C1 : S_DONE;
         end
         S_C1:   state_in = S_C1W;
         S_C1W:  state_in = S_C2;
         S_C2:   state_in = S_C2W;
         S_C2W:  state_in = S_FB;
         S_FB:   state_in = S_FBW;
         S_FBW:  state_in = S_AY;
         S_AY:   state_in = S_AYW;
         S_AYW:  state_in = S_AM;
         S_AM:   state_in = S_AMW;
         S_AMW:  state_in = (stg_ff == STG_LAST) ? S_DRY : S_AY;
         S_DRY:  state_in = S_DRYW;
         S_DRYW: state_in = S_WET;
         S_WET:  state_in = S_WETW;
         S_WETW: state_in = S_DS;
         S_DS:   state_in = S_DW;
         S_DW: if (div_done) begin
            state_in = ch_ff ? S_DONE : S_FB;
         end
         S_DONE: if (!rsp_valid_ff || rsp_tready) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b0;
         phase_step_ff    <= sap_pkg::PHASE_STEP_RST;
         depth_gain_ff    <= sap_pkg::DEPTH_GAIN_RST;
         feedback_gain_ff <= sap_pkg::FEEDBACK_GAIN_RST;
         dry_gain_ff      <= sap_pkg::DRY_GAIN_RST;
         wet_gain_ff      <= sap_pkg::WET_GAIN_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            sap_pkg::CSR_ENABLE:        enable_ff        <= csr_wdata[0];
            sap_pkg::CSR_PHASE_STEP:    phase_step_ff    <= csr_wdata[sap_pkg::STEP_W-1:0];
            sap_pkg::CSR_DEPTH_GAIN:    depth_gain_ff    <= csr_wdata[sap_pkg::GAIN_W-1:0];
            sap_pkg::CSR_FEEDBACK_GAIN: feedback_gain_ff <= csr_wdata[sap_pkg::FBG_W-1:0];
            sap_pkg::CSR_DRY_GAIN:      dry_gain_ff      <= csr_wdata[sap_pkg::GAIN_W-1:0];
            sap_pkg::CSR_WET_GAIN:      wet_gain_ff      <= csr_wdata[sap_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         fb_ff[0]     <= '0;
         fb_ff[1]     <= '0;
         for (int k = 0; k < STAGE_COUNT; k++) begin
            mem_ff[0][k] <= '0;
            mem_ff[1][k] <= '0;
         end
         rsp_valid_ff <= 1'b0;
         ch_ff        <= 1'b0;
         stg_ff       <= '0;
      end else begin
         state_ff <= state_in;
         // load a fresh result or drop the one just taken
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: if (accept) begin
               if (enable_ff) begin
                  phase_ff <= phase_ff + sap_pkg::PHASE_W'(phase_step_ff);
               end
               ch_ff <= 1'b0;
            end
            S_FBW:  stg_ff <= '0;
            S_AMW: begin
               mem_ff[ch_ff][stg_ff] <= m_val;
               if (stg_ff != STG_LAST) begin
                  stg_ff <= stg_ff + 1'b1;
               end
            end
            S_DW: if (div_done) begin
               fb_ff[ch_ff] <= div_clip;
               ch_ff        <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: if (accept) begin
            smp_ff[0] <= req_tdata[SB-1:0];
            smp_ff[1] <= req_tdata[2*SB-1:SB];
            out_ff[0] <= req_tdata[SB-1:0];
            out_ff[1] <= req_tdata[2*SB-1:SB];
            last_ff   <= req_tlast;
         end
         S_C1W, S_C2W: c_ff <= sap_pkg::COEF_W'(p_rnd);
         S_FBW:  x_ff <= fb_sum;
         S_AYW: begin
            xs_ff <= x_ff;
            x_ff  <= y_val;
         end
         S_DRYW: acc_ff <= pw;
         S_WETW: out_ff[ch_ff] <= mix;
         S_DONE: if (!rsp_valid_ff || rsp_tready) begin
            rsp_data_ff <= TD_W'({out_ff[1], out_ff[0]});
            rsp_last_ff <= last_ff;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (accept && !enable_ff) |=> state_ff == S_DONE)
      else $error("bypass transaction did not go straight to output");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DS) |-> !div_busy)
      else $error("soft clip started while divider busy");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_C1 && state_ff != S_DONE) |-> $stable(phase_ff))
      else $error("LFO phase moved mid transaction");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_data_ff))
      else $error("result overwritten before it was taken");
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the stereo allpass phaser: stream driver, checker and predictor.
`timescale 1ns / 100ps
module tb_top;

   localparam int SAMPLE_W = 24;
   localparam int INNER_W  = SAMPLE_W + 4;
   localparam int FRAC_W   = SAMPLE_W - 1;
   localparam int STAGES   = 4;

   typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       last;
   } pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [sap_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [sap_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   stereo_allpass_phaser dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow registers and phaser state
   logic             fx_enable = 1'b0;
   logic [23:0]      lfo_step = sap_pkg::PHASE_STEP_RST;
   longint           depth = sap_pkg::DEPTH_GAIN_RST;
   longint           fb_gain = 16384;
   longint           dry = sap_pkg::DRY_GAIN_RST;
   longint           wet = sap_pkg::WET_GAIN_RST;
   logic [31:0]      lfo_acc = '0;
   longint           fb_store [2] = '{0, 0};
   longint           stage_mem [2][STAGES] = '{'{0, 0, 0, 0}, '{0, 0, 0, 0}};

   pair_type sample_queue [$];
   pair_type pair_expected [$];
   int    fail_count = 0;
   int    rsp_count = 0;
   int    stall_mode = 0;

   function automatic longint sat(longint v, int bits);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
   endfunction

   function automatic longint rnd_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // Q1.15 sine of the table point selected by the top phase bits
   function automatic longint lfo_sine(logic [31:0] ph);
      longint unsigned t, u, x, x2, term;
      longint sum, r;
      logic [1:0] quad;
      t = longint'(ph[31:24]) << 24;
      quad = t[31:30];
      u = t & 64'h3FFF_FFFF;
      if (quad[0]) begin
         u = 64'h4000_0000 - u;
      end
      x = (u * sap_pkg::HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 5; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum -= longint'(term);
         end else begin
            sum += longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 16384) >>> 15;
      if (r > 32767) begin
         r = 32767;
      end
      return quad[1] ? -r : r;
   endfunction

   // y / (1 + |y|), magnitude rounded toward zero
   function automatic longint soft_limit(longint y);
      longint unsigned one, a, d, q;
      longint m;
      one = 64'd1 << FRAC_W;
      a = y < 0 ? -y : y;
      d = one + a;
      q = (one * one + d - 1) / d;
      m = longint'(one - q);
      return y < 0 ? -m : m;
   endfunction

   function automatic longint phase_channel(int ch, longint din, longint c);
      longint x, y;
      x = sat(din + rnd_shift(fb_store[ch] * fb_gain, 15), INNER_W);
      for (int j = 0; j < STAGES; j++) begin
         y = sat(stage_mem[ch][j] - rnd_shift(c * x, 15), INNER_W);
         stage_mem[ch][j] = sat(x + rnd_shift(c * y, 15), INNER_W);
         x = y;
      end
      fb_store[ch] = sat(soft_limit(x), SAMPLE_W);
      return sat(rnd_shift(din * dry + x * wet, 15), SAMPLE_W);
   endfunction

   function automatic pair_type phaser_out(logic [47:0] data, logic last);
      pair_type p;
      longint c;
      p.left = data[23:0];
      p.right = data[47:24];
      p.last = last;
      if (fx_enable) begin
         lfo_acc = lfo_acc + 32'(lfo_step);
         c = rnd_shift(lfo_sine(lfo_acc) * depth, 15);
         c = rnd_shift(c * 26214, 15);
         p.left = phase_channel(0, longint'(p.left), c);
         p.right = phase_channel(1, longint'(p.right), c);
      end
      return p;
   endfunction

   // sender: bursts with random gaps
   pair_type next_pair;
   int    burst_left = 0;
   int    gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            next_pair = sample_queue.pop_front();
            req_tdata <= {next_pair.right, next_pair.left};
            req_tlast <= next_pair.last;
            req_tvalid <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            if (burst_left == 0) begin
               gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 130)
                                                      : $urandom_range(0, 4);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // predict on every accepted input transaction
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         pair_expected.push_back(phaser_out(req_tdata, req_tlast));
      end
   end

   // receiver: stall pattern per phase, plus one long hold-off
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;
   int  ready_tick = 0;
   always @(posedge clock) begin
      ready_tick++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && rsp_count == 300) begin
         long_hold_done = 1'b1;
         hold_left = 3000;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            default: rsp_tready <= (ready_tick % 7) < 2;
         endcase
      end
   end

   pair_type want;
   pair_type got;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         got.left = rsp_tdata[23:0];
         got.right = rsp_tdata[47:24];
         got.last = rsp_tlast;
         if (pair_expected.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %h %h", $time,
                     got.left, got.right);
            fail_count++;
         end else begin
            want = pair_expected.pop_front();
            if (got.left !== want.left) begin
               $display("%0t left_out: expected %h actual %h", $time, want.left, got.left);
               fail_count++;
            end
            if (got.right !== want.right) begin
               $display("%0t right_out: expected %h actual %h", $time, want.right, got.right);
               fail_count++;
            end
            if (got.last !== want.last) begin
               $display("%0t tlast: expected %b actual %b", $time, want.last, got.last);
               fail_count++;
            end
         end
      end
   end

   task automatic write_reg(logic [sap_pkg::CSR_ADDR_W-1:0] idx, longint val, int width);
      logic [sap_pkg::CSR_DATA_W-1:0] word;
      word = sap_pkg::CSR_DATA_W'(val);
      // junk above the register width must be dropped
      if (width < sap_pkg::CSR_DATA_W) begin
         word = (word & ((24'd1 << width) - 1)) | (sap_pkg::CSR_DATA_W'($urandom) << width);
      end
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= word;
      case (idx)
         sap_pkg::CSR_ENABLE:        fx_enable = word[0];
         sap_pkg::CSR_PHASE_STEP:    lfo_step = word;
         sap_pkg::CSR_DEPTH_GAIN:    depth = word[14:0];
         sap_pkg::CSR_FEEDBACK_GAIN: fb_gain = longint'($signed(word[15:0]));
         sap_pkg::CSR_DRY_GAIN:      dry = word[14:0];
         sap_pkg::CSR_WET_GAIN:      wet = word[14:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_all(longint en, longint st, longint dp, longint fb, longint dr, longint wt);
      write_reg(sap_pkg::CSR_ENABLE, en, 1);
      write_reg(sap_pkg::CSR_PHASE_STEP, st, sap_pkg::STEP_W);
      write_reg(sap_pkg::CSR_DEPTH_GAIN, dp, sap_pkg::GAIN_W);
      write_reg(sap_pkg::CSR_FEEDBACK_GAIN, fb, sap_pkg::FBG_W);
      write_reg(sap_pkg::CSR_DRY_GAIN, dr, sap_pkg::GAIN_W);
      write_reg(sap_pkg::CSR_WET_GAIN, wt, sap_pkg::GAIN_W);
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (sample_queue.size() != 0 || req_tvalid || pair_expected.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [23:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2, 3: return 24'($signed($urandom_range(0, 2000)) - 1000);
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic push(logic [23:0] l, logic [23:0] r, logic last);
      pair_type p;
      p.left = l;
      p.right = r;
      p.last = last;
      sample_queue.push_back(p);
   endtask

   task automatic push_random(int n);
      for (int i = 0; i < n; i++) begin
         push(pick_sample(), pick_sample(), $urandom_range(0, 1));
      end
   endtask

   task automatic push_directed();
      push(24'h000000, 24'h000000, 1'b0);
      push(24'h7FFFFF, 24'h800000, 1'b1);
      push(24'h800000, 24'h7FFFFF, 1'b0);
      push(24'h7FFFFF, 24'h7FFFFF, 1'b0);
      push(24'h800000, 24'h800000, 1'b1);
      push(24'h000001, 24'hFFFFFF, 1'b0);
      push(24'h555555, 24'hAAAAAA, 1'b1);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // pass-through straight after reset
      push_directed();
      wait_idle();
      write_reg(sap_pkg::CSR_ENABLE, 1, 1);
      push_directed();
      push_directed();
      wait_idle();
      stall_mode = 1;
      push_random(100);
      wait_idle();
      // extremes, fast LFO
      stall_mode = 2;
      set_all(1, 24'hFFFFFF, 32767, 31130, 32767, 32767);
      push_random(80);
      wait_idle();
      stall_mode = 0;
      set_all(1, 0, 0, -31130, 0, 0);
      push_random(30);
      wait_idle();
      set_all(1, 24'h123456, 32767, -32768, 32767, 32767);
      push_random(50);
      wait_idle();
      write_reg(sap_pkg::CSR_FEEDBACK_GAIN, 32767, sap_pkg::FBG_W);
      push_random(40);
      wait_idle();
      // bypass mid-stream: state must hold
      write_reg(sap_pkg::CSR_ENABLE, 0, 1);
      push_random(30);
      wait_idle();
      write_reg(sap_pkg::CSR_ENABLE, 1, 1);
      push_random(30);
      wait_idle();
      for (int ph = 0; ph < 4; ph++) begin
         stall_mode = $urandom_range(0, 2);
         set_all(1, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 32767),
                 longint'($urandom_range(0, 62260)) - 31130, $urandom_range(0, 32767),
                 $urandom_range(0, 32767));
         push_random(60);
         wait_idle();
      end
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pair_expected.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/sap_pkg.sv
src/sap_mul.sv
src/sap_clip.sv
src/stereo_allpass_phaser.sv
tb/tb_top.sv
